// ----- hw/rtl/u16u8_pkg.sv -----
// u16u8_pkg: word types and UTF-16/UTF-8 constants for the transcoder.
// No dependencies; used by utf16_to_utf8_transcoder.
package u16u8_pkg;

    // Input word: one UTF-16 code unit and its end-of-string mark.
    typedef struct packed {
        logic [15:0] utf16_unit;
        logic        end_of_string;
    } unit_word_t;

    // Output word: one UTF-8 octet, flagged on the last octet of a unit.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } byte_word_t;

    // One code point encoded: up to four octets, the first in bytes[3].
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    localparam int unsigned MaxBytes = 6;
    localparam int unsigned CntW     = $clog2(MaxBytes + 1);

    localparam logic [4:0]  SurTag      = 5'h1B;       // unit[15:11] of any surrogate
    localparam logic [20:0] ReplCp      = 21'h00FFFD;
    localparam logic [20:0] SuppBase    = 21'h010000;
    localparam logic [20:0] Lim1        = 21'h000080;
    localparam logic [20:0] Lim2        = 21'h000800;
    localparam logic [20:0] Lim3        = 21'h010000;
    localparam logic [7:0]  ReplByte0   = 8'hEF;
    localparam logic [7:0]  ReplByte1   = 8'hBF;
    localparam logic [7:0]  ReplByte2   = 8'hBD;

endpackage

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// utf16_to_utf8_transcoder: UTF-16 code units in, UTF-8 octets out.
// Depends on u16u8_pkg (word types, constants).
//
//  channel | direction | payload            | handshake
//  --------+-----------+--------------------+----------------------------
//  unit    | in        | utf16_unit, eos    | unit_valid / unit_ready
//  byte    | out       | out_byte, last     | byte_valid / byte_ready
//
// A unit is encoded in its accept cycle into a six-octet shift buffer.
// The buffer hands out one octet per cycle while byte_ready is high; a unit
// yields 1 to 6 octets, and a held high surrogate yields no output.
// A new unit is taken in the cycle the last octet of the previous one leaves.
// Byte channel stalls simply hold the buffer head. Reset clears the buffer
// count and the surrogate hold.
module utf16_to_utf8_transcoder
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   unit_valid,
    output logic                   unit_ready,
    input  u16u8_pkg::unit_word_t  unit_word,
    output logic                   byte_valid,
    input  logic                   byte_ready,
    output u16u8_pkg::byte_word_t  byte_word
);

    // Encode one code point into 1 to 4 octets.
    function automatic u16u8_pkg::enc_t encode_cp(input logic [20:0] cp);
        u16u8_pkg::enc_t e;
        e.bytes = '0;
        if (cp < u16u8_pkg::Lim1)
        begin
            e.bytes[3] = {1'b0, cp[6:0]};
            e.len      = 3'd1;
        end
        else if (cp < u16u8_pkg::Lim2)
        begin
            e.bytes[3] = {3'b110, cp[10:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end
        else if (cp < u16u8_pkg::Lim3)
        begin
            e.bytes[3] = {4'b1110, cp[15:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end
        else
        begin
            e.bytes[3] = {5'b11110, cp[20:18]};
            e.bytes[2] = {2'b10, cp[17:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[0] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

    localparam int unsigned CntW = u16u8_pkg::CntW;

    // Surrogate hold.
    logic       pend_valid_reg, pend_valid_next;
    logic [9:0] pend_bits_reg,  pend_bits_next;

    // Octet buffer, head in the top slot, and count of octets left.
    logic [u16u8_pkg::MaxBytes-1:0][7:0] shift_reg, shift_next;
    logic [CntW-1:0]                     rem_reg,   rem_next;

    logic            is_sur, is_low, is_high, eos;
    logic            accept, take, busy, last_out;
    logic            rep_prefix, emit_cp;
    logic [20:0]     cp;
    u16u8_pkg::enc_t enc;
    logic [CntW-1:0] load_cnt;
    logic [u16u8_pkg::MaxBytes-1:0][7:0] load_bytes;

    assign eos     = unit_word.end_of_string;
    assign is_sur  = (unit_word.utf16_unit[15:11] == u16u8_pkg::SurTag);
    assign is_low  = is_sur && unit_word.utf16_unit[10];
    assign is_high = is_sur && !unit_word.utf16_unit[10];

    assign busy       = (rem_reg != '0);
    assign last_out   = (rem_reg == CntW'(1));
    assign take       = busy && byte_ready;
    assign unit_ready = !busy || (byte_ready && last_out);
    assign accept     = unit_valid && unit_ready;

    assign byte_valid            = busy;
    assign byte_word.out_byte    = shift_reg[u16u8_pkg::MaxBytes-1];
    assign byte_word.last_of_run = last_out;

    always_comb
    begin
        // held high surrogate not completed: replacement first
        rep_prefix = pend_valid_reg && !is_low;
        // a high surrogate without end mark is only held
        emit_cp    = !(is_high && !eos);

        priority if (pend_valid_reg && is_low)
            cp = u16u8_pkg::SuppBase + {1'b0, pend_bits_reg, unit_word.utf16_unit[9:0]};
        else if (is_sur)
            cp = u16u8_pkg::ReplCp;
        else
            cp = {5'd0, unit_word.utf16_unit};

        enc = encode_cp(cp);
        if (!emit_cp)
            enc.len = 3'd0;

        if (rep_prefix)
        begin
            load_bytes = {u16u8_pkg::ReplByte0, u16u8_pkg::ReplByte1,
                          u16u8_pkg::ReplByte2, enc.bytes[3:1]};
            load_cnt   = CntW'(3) + CntW'(enc.len);
        end
        else
        begin
            load_bytes = {enc.bytes, 16'h0000};
            load_cnt   = CntW'(enc.len);
        end
    end

    always_comb
    begin
        shift_next      = shift_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;
        if (accept)
        begin
            shift_next      = load_bytes;
            rem_next        = load_cnt;
            pend_valid_next = is_high && !eos;
            pend_bits_next  = (is_high && !eos) ? unit_word.utf16_unit[9:0] : 10'd0;
        end
        else if (take)
        begin
            shift_next = {shift_reg[u16u8_pkg::MaxBytes-2:0], 8'h00};
            rem_next   = rem_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= '0;
        end
        else
        begin
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
        end
    end

    // payload buffer, no reset needed
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // Assertions

    // octet count never exceeds the buffer
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= CntW'(u16u8_pkg::MaxBytes))
        else $error("octet count out of range");

    // a unit with the end mark never leaves a surrogate held
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eos) |=> !pend_valid_reg)
        else $error("surrogate held across end of string");

    // a held high surrogate with nothing pending yields no octets
    a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_high && !eos && !pend_valid_reg) |=> (!busy && pend_valid_reg))
        else $error("held high surrogate produced output");

    // a new unit is taken only when the buffer drains in that cycle
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && busy) |-> (take && last_out))
        else $error("unit accepted over pending octets");

endmodule
